// ===== rtl/tfs_pkg.sv =====
package tfs_pkg;

    localparam int MAX_FRAMES_DEF = 16;

    localparam int CNT_W       = 5;
    localparam int MODE_W      = 2;
    localparam int CMD_W       = 2;
    localparam int IDX_W       = 8;
    localparam int TIME_W      = 32;
    localparam int HANDLE_W    = 32;
    localparam int ENTRY_W     = HANDLE_W + TIME_W;
    localparam int OUT_FRAME_W = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAY_MODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOPPED     = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK,
        CMD_WRITE,
        CMD_SET,
        CMD_RESTART
    } cmd_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOOP,
        MODE_PINGPONG,
        MODE_ONCE,
        MODE_ONCE_ALT
    } mode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_TICK_UPD,
        S_DIV,
        S_SET,
        S_OUT_RD,
        S_OUT_LD
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [TIME_W-1:0]   delta_time;
        logic [IDX_W-1:0]    frame_index;
        logic [HANDLE_W-1:0] entry_handle;
        logic [TIME_W-1:0]   entry_duration;
    } in_item_t;

    typedef struct packed {
        logic [OUT_FRAME_W-1:0] current_frame;
        logic [HANDLE_W-1:0]    current_handle;
        logic                   going_backward;
        logic                   frame_advanced;
    } out_item_t;

    typedef struct packed {
        logic capture;
        logic wr_en;
        logic restart;
        logic tick_upd;
        logic div_step;
        logic set_pos;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic tick_ok;
        logic set_ok;
    } dp_status_t;

endpackage

// ===== rtl/tfs_ram.sv =====
module tfs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/tfs_ctrl.sv =====
module tfs_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  logic                   out_stall,
    input  tfs_pkg::dp_status_t    st,
    output tfs_pkg::ctrl_cmd_t     ctl
);
    import tfs_pkg::*;

    localparam int SW = $clog2(IDX_W);

    state_t          state_reg;
    state_t          state_next;
    logic [SW-1:0]   step_reg;
    logic [SW-1:0]   step_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;
    logic            last_step;

    assign out_free  = !out_valid_reg || !out_stall;
    assign last_step = (step_reg == SW'(IDX_W - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (st.cmd)
                    CMD_TICK:    state_next = st.tick_ok ? S_TICK_UPD : S_OUT_RD;
                    CMD_SET:     state_next = st.set_ok ? S_DIV : S_OUT_RD;
                    CMD_WRITE:   state_next = S_OUT_RD;
                    CMD_RESTART: state_next = S_OUT_RD;
                    default:     state_next = S_OUT_RD;
                endcase
            end
            S_TICK_UPD: state_next = S_OUT_RD;
            S_DIV:
            begin
                if (last_step)
                begin
                    state_next = S_SET;
                end
            end
            S_SET:      state_next = S_OUT_RD;
            S_OUT_RD:   state_next = S_OUT_LD;
            S_OUT_LD:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        unique case (state_reg)
            S_IDLE:     ctl.capture  = in_valid;
            S_EXEC:
            begin
                ctl.wr_en   = (st.cmd == CMD_WRITE);
                ctl.restart = (st.cmd == CMD_RESTART);
            end
            S_TICK_UPD: ctl.tick_upd = 1'b1;
            S_DIV:      ctl.div_step = 1'b1;
            S_SET:      ctl.set_pos  = 1'b1;
            S_OUT_RD:   ctl          = '0;
            S_OUT_LD:   ctl.out_load = out_free;
            default:    ctl          = '0;
        endcase
    end

    assign step_next      = (state_reg == S_DIV) ? step_reg + SW'(1) : '0;
    assign out_valid_next = ctl.out_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/tfs_dp.sv =====
module tfs_dp #(
    parameter int MAX_FRAMES = tfs_pkg::MAX_FRAMES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tfs_pkg::ctrl_cmd_t                ctl,
    output tfs_pkg::dp_status_t               st,
    input  tfs_pkg::in_item_t                 in_data,
    input  logic                              cfg_we,
    input  logic [tfs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tfs_pkg::CFG_DATA_W-1:0]    cfg_data,
    output tfs_pkg::out_item_t                out_data
);
    import tfs_pkg::*;

    localparam int PW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int MW = $clog2(MAX_FRAMES + 1);
    localparam int XW = (MW > CNT_W) ? MW : CNT_W;
    localparam int RW = (PW > CNT_W) ? PW : CNT_W;
    localparam int OW = (PW > OUT_FRAME_W) ? PW : OUT_FRAME_W;
    localparam int IW = (MW > IDX_W) ? MW : IDX_W;

    in_item_t              item_reg;
    in_item_t              item_next;
    logic [CNT_W-1:0]      frame_count_reg;
    logic [CNT_W-1:0]      frame_count_next;
    mode_t                 play_mode_reg;
    mode_t                 play_mode_next;
    logic                  stopped_reg;
    logic                  stopped_next;
    logic [TIME_W-1:0]     elapsed_reg;
    logic [TIME_W-1:0]     elapsed_next;
    logic [PW-1:0]         pos_reg;
    logic [PW-1:0]         pos_next;
    logic                  back_reg;
    logic                  back_next;
    logic                  adv_reg;
    logic                  adv_next;
    logic [IDX_W-1:0]      dvd_reg;
    logic [IDX_W-1:0]      dvd_next;
    logic [CNT_W-1:0]      rem_reg;
    logic [CNT_W-1:0]      rem_next;
    out_item_t             out_reg;
    out_item_t             out_next;

    logic [ENTRY_W-1:0]    ram_rdata;
    logic                  ram_we;
    logic [TIME_W-1:0]     dur;
    logic [HANDLE_W-1:0]   handle;

    logic [XW-1:0]         fc_x;
    logic [XW-1:0]         cnt_x;
    logic [XW-1:0]         p_x;
    logic [XW-1:0]         nxt_x;
    logic                  wrap;
    logic [XW-1:0]         adv_pos_x;
    logic                  adv_back;

    logic [TIME_W:0]       sum;
    logic [TIME_W-1:0]     sat;
    logic                  reached;

    logic [CNT_W:0]        div_t;
    logic [CNT_W:0]        div_sub;
    logic                  div_ge;
    logic [RW-1:0]         rem_x;
    logic [OW-1:0]         pos_o;

    assign dur    = ram_rdata[TIME_W-1:0];
    assign handle = ram_rdata[ENTRY_W-1:TIME_W];

    assign fc_x  = XW'(frame_count_reg);
    assign cnt_x = (fc_x > XW'(MAX_FRAMES)) ? XW'(MAX_FRAMES) : fc_x;
    assign p_x   = XW'(pos_reg);
    assign nxt_x = p_x + XW'(1);
    assign wrap  = (nxt_x >= cnt_x);

    always_comb
    begin
        adv_pos_x = p_x;
        adv_back  = back_reg;
        case (play_mode_reg) inside
            MODE_LOOP:
            begin
                adv_pos_x = wrap ? '0 : nxt_x;
            end
            MODE_PINGPONG:
            begin
                if (!back_reg)
                begin
                    if (wrap)
                    begin
                        adv_pos_x = cnt_x - XW'(2);
                        adv_back  = 1'b1;
                    end
                    else
                    begin
                        adv_pos_x = nxt_x;
                    end
                end
                else if (p_x == '0)
                begin
                    adv_pos_x = XW'(1);
                    adv_back  = 1'b0;
                end
                else
                begin
                    adv_pos_x = p_x - XW'(1);
                end
            end
            MODE_ONCE, MODE_ONCE_ALT:
            begin
                adv_pos_x = wrap ? cnt_x - XW'(1) : nxt_x;
            end
            default:
            begin
                adv_pos_x = p_x;
            end
        endcase
    end

    // saturating accumulate, then compare against the frame duration
    assign sum     = {1'b0, elapsed_reg} + {1'b0, item_reg.delta_time};
    assign sat     = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    assign reached = (sat >= dur);

    // one restoring remainder step per cycle
    assign div_t   = {rem_reg, dvd_reg[IDX_W-1]};
    assign div_ge  = (div_t >= (CNT_W+1)'(cnt_x[CNT_W-1:0]));
    assign div_sub = div_t - (CNT_W+1)'(cnt_x[CNT_W-1:0]);
    assign rem_x   = RW'(rem_reg);
    assign pos_o   = OW'(pos_reg);

    assign ram_we = ctl.wr_en && (IW'(item_reg.frame_index) < IW'(MAX_FRAMES));

    always_comb
    begin
        item_next        = item_reg;
        frame_count_next = frame_count_reg;
        play_mode_next   = play_mode_reg;
        stopped_next     = stopped_reg;
        elapsed_next     = elapsed_reg;
        pos_next         = pos_reg;
        back_next        = back_reg;
        adv_next         = adv_reg;
        dvd_next         = dvd_reg;
        rem_next         = rem_reg;
        out_next         = out_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAME_COUNT: frame_count_next = cfg_data[CNT_W-1:0];
                CFG_PLAY_MODE:   play_mode_next   = mode_t'(cfg_data[MODE_W-1:0]);
                CFG_STOPPED:     stopped_next     = cfg_data[0];
                default:         stopped_next     = stopped_reg;
            endcase
        end

        if (ctl.capture)
        begin
            item_next = in_data;
            adv_next  = 1'b0;
            dvd_next  = in_data.frame_index;
            rem_next  = '0;
        end

        if (ctl.restart)
        begin
            pos_next     = '0;
            elapsed_next = '0;
            back_next    = 1'b0;
        end

        if (ctl.tick_upd)
        begin
            if (reached)
            begin
                elapsed_next = '0;
                pos_next     = adv_pos_x[PW-1:0];
                back_next    = adv_back;
                adv_next     = 1'b1;
            end
            else
            begin
                elapsed_next = sat;
            end
        end

        if (ctl.div_step)
        begin
            rem_next = div_ge ? div_sub[CNT_W-1:0] : div_t[CNT_W-1:0];
            dvd_next = {dvd_reg[IDX_W-2:0], 1'b0};
        end

        if (ctl.set_pos)
        begin
            pos_next = rem_x[PW-1:0];
        end

        if (ctl.out_load)
        begin
            out_next.current_frame  = pos_o[OUT_FRAME_W-1:0];
            out_next.current_handle = handle;
            out_next.going_backward = back_reg;
            out_next.frame_advanced = adv_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= '0;
            play_mode_reg   <= MODE_LOOP;
            stopped_reg     <= 1'b0;
            elapsed_reg     <= '0;
            pos_reg         <= '0;
            back_reg        <= 1'b0;
        end
        else
        begin
            frame_count_reg <= frame_count_next;
            play_mode_reg   <= play_mode_next;
            stopped_reg     <= stopped_next;
            elapsed_reg     <= elapsed_next;
            pos_reg         <= pos_next;
            back_reg        <= back_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        adv_reg  <= adv_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        out_reg  <= out_next;
    end

    tfs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_FRAMES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (item_reg.frame_index[PW-1:0]),
        .wdata ({item_reg.entry_handle, item_reg.entry_duration}),
        .raddr (pos_reg),
        .rdata (ram_rdata)
    );

    assign st.cmd     = cmd_t'(item_reg.cmd);
    assign st.tick_ok = !stopped_reg && (cnt_x >= XW'(2));
    assign st.set_ok  = (cnt_x != '0);
    assign out_data   = out_reg;

endmodule

// ===== rtl/texture_frame_sequencer.sv =====
// Sprite frame animation sequencer.
// Input channel (in_valid / in_stall / in_data) carries one command per
// transaction: tick, write table entry, set frame, restart. Every accepted
// transaction yields exactly one result transaction on the output channel
// (out_valid / out_stall / out_data): current frame, its handle, ping-pong
// direction and whether a tick advanced the frame.
// Configuration port (cfg_valid / cfg_ready, cfg_index, cfg_data) is always
// ready; index 0 frame count, 1 play mode, 2 stopped. Write it only while idle.
// After accept the command executes; a tick that runs then updates the frame
// position, a set frame runs a bit-serial remainder sequencer, and the result
// is read from the frame table and loaded into the output register. One
// transaction is in flight at a time; a new one is accepted once its result has
// entered the output register.
// When out_stall is high the result holds in the output register and the
// block finishes its next transaction but waits to deliver it.
// Reset clears the configuration registers, frame position, elapsed time and
// direction; the frame table is undefined until written.
module texture_frame_sequencer #(
    parameter int MAX_FRAMES = tfs_pkg::MAX_FRAMES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  tfs_pkg::in_item_t               in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output tfs_pkg::out_item_t              out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tfs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tfs_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tfs_pkg::*;

    ctrl_cmd_t  ctl;
    dp_status_t st;

    assign cfg_ready = 1'b1;

    tfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .st        (st),
        .ctl       (ctl)
    );

    tfs_dp #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .st        (st),
        .in_data   (in_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (out_data)
    );

endmodule

// ===== rtl/tfs_checker.sv =====
module tfs_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input tfs_pkg::in_item_t               in_data,
    input logic                            out_valid,
    input logic                            out_stall,
    input tfs_pkg::out_item_t              out_data,
    input logic                            cfg_valid,
    input logic                            cfg_ready,
    input logic [tfs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input logic [tfs_pkg::CFG_DATA_W-1:0]  cfg_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second transaction accepted while busy");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a transaction in progress");

    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid) ##1 !$rose(out_valid))
        else $error("result too early after accept");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind texture_frame_sequencer tfs_checker u_tfs_checker (.*);

// ===== tb/texture_frame_sequencer_tb.sv =====
module texture_frame_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tfs_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int PHASES = 12;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int HOLD_AT = 700;
    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   duration;
    } frame_rec_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    in_item_t   in_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_item_t  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predicted block state
    frame_rec_t         frame_store [TABLE_DEPTH];
    logic [CNT_W-1:0]   count_reg;
    mode_t              mode_reg;
    logic               stop_reg;
    logic [TIME_W-1:0]  anim_elapsed;
    logic [3:0]         anim_pos;
    logic               anim_backward;

    in_item_t    pending_items [$];
    out_item_t   frame_reports [$];
    out_item_t   want;
    int          reports_seen = 0;
    int          mismatches = 0;
    bit          quiet = 1'b0;

    int unsigned gap_left;
    int unsigned stall_left;
    bit          hold_done;
    int unsigned idle_cycles = 0;

    texture_frame_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned pause_len();
        int unsigned r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // advances the predicted sequencer by one transaction, returns the report it yields
    function automatic out_item_t sequence_frame(in_item_t it);
        logic [CNT_W-1:0]  cnt;
        logic [CNT_W-1:0]  next;
        logic [CNT_W-1:0]  edge_pos;
        logic [TIME_W:0]   sum;
        logic [IDX_W-1:0]  rem;
        logic              advanced;
        out_item_t         res;
        cnt = (count_reg > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : count_reg;
        advanced = 1'b0;
        case (it.cmd)
            CMD_TICK:
            begin
                if (!stop_reg && cnt >= 2)
                begin
                    sum = {1'b0, anim_elapsed} + {1'b0, it.delta_time};
                    anim_elapsed = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
                    if (anim_elapsed >= frame_store[anim_pos].duration)
                    begin
                        anim_elapsed = '0;
                        advanced = 1'b1;
                        next = {1'b0, anim_pos} + 5'd1;
                        case (mode_reg)
                            MODE_LOOP:
                                anim_pos = (next >= cnt) ? 4'd0 : next[3:0];
                            MODE_PINGPONG:
                            begin
                                if (!anim_backward)
                                begin
                                    if (next >= cnt)
                                    begin
                                        edge_pos = cnt - 5'd2;
                                        anim_pos = edge_pos[3:0];
                                        anim_backward = 1'b1;
                                    end
                                    else
                                        anim_pos = next[3:0];
                                end
                                else if (anim_pos == 4'd0)
                                begin
                                    anim_pos = 4'd1;
                                    anim_backward = 1'b0;
                                end
                                else
                                    anim_pos = anim_pos - 4'd1;
                            end
                            default:
                            begin
                                edge_pos = cnt - 5'd1;
                                anim_pos = (next >= cnt) ? edge_pos[3:0] : next[3:0];
                            end
                        endcase
                    end
                end
            end
            CMD_WRITE:
            begin
                if (it.frame_index < TABLE_DEPTH)
                    frame_store[it.frame_index[3:0]] = '{it.entry_handle, it.entry_duration};
            end
            CMD_SET:
            begin
                if (cnt != 0)
                begin
                    rem = it.frame_index % {3'b000, cnt};
                    anim_pos = rem[3:0];
                end
            end
            default:
            begin
                anim_pos = 4'd0;
                anim_elapsed = '0;
                anim_backward = 1'b0;
            end
        endcase
        res.current_frame = anim_pos;
        res.current_handle = frame_store[anim_pos].handle;
        res.going_backward = anim_backward;
        res.frame_advanced = advanced;
        return res;
    endfunction

    function automatic in_item_t make_item(cmd_t c, logic [TIME_W-1:0] dt, logic [IDX_W-1:0] idx,
                                           logic [HANDLE_W-1:0] h, logic [TIME_W-1:0] dur);
        in_item_t it;
        it.cmd = c;
        it.delta_time = dt;
        it.frame_index = idx;
        it.entry_handle = h;
        it.entry_duration = dur;
        return it;
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            it.cmd = CMD_TICK;
        else if (r < 75)
            it.cmd = CMD_WRITE;
        else if (r < 90)
            it.cmd = CMD_SET;
        else
            it.cmd = CMD_RESTART;
        r = $urandom_range(0, 99);
        if (r < 70)
            it.delta_time = $urandom_range(0, 32'h0002_0000);
        else if (r < 80)
            it.delta_time = '0;
        else
            it.delta_time = $urandom();
        it.frame_index = IDX_W'($urandom_range(0, 255));
        if (it.cmd == CMD_WRITE && $urandom_range(0, 9) < 8)
            it.frame_index = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
        it.entry_handle = $urandom();
        r = $urandom_range(0, 99);
        if (r < 70)
            it.entry_duration = $urandom_range(0, 32'h0003_0000);
        else if (r < 85)
            it.entry_duration = '0;
        else
            it.entry_duration = $urandom();
        return it;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_FRAME_COUNT: count_reg = value[CNT_W-1:0];
            CFG_PLAY_MODE:   mode_reg = mode_t'(value[MODE_W-1:0]);
            CFG_STOPPED:     stop_reg = value[0];
            default:         ;
        endcase
    endtask

    task automatic drain();
        @(negedge clk);
        while (pending_items.size() != 0 || in_valid || frame_reports.size() != 0)
            @(negedge clk);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                frame_reports.push_back(sequence_frame(in_data));
            if (!(in_valid && in_stall))
            begin
                if (gap_left != 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_items.size() != 0)
                begin
                    in_valid <= 1'b1;
                    in_data <= pending_items.pop_front();
                    gap_left <= pause_len();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                reports_seen++;
                if (frame_reports.size() == 0)
                begin
                    $error("result transaction with nothing outstanding");
                    mismatches++;
                end
                else
                begin
                    want = frame_reports.pop_front();
                    if (out_data.current_frame !== want.current_frame)
                    begin
                        $error("current_frame: expected %0d, got %0d",
                               want.current_frame, out_data.current_frame);
                        mismatches++;
                    end
                    if (out_data.current_handle !== want.current_handle)
                    begin
                        $error("current_handle: expected %h, got %h",
                               want.current_handle, out_data.current_handle);
                        mismatches++;
                    end
                    if (out_data.going_backward !== want.going_backward)
                    begin
                        $error("going_backward: expected %0b, got %0b",
                               want.going_backward, out_data.going_backward);
                        mismatches++;
                    end
                    if (out_data.frame_advanced !== want.frame_advanced)
                    begin
                        $error("frame_advanced: expected %0b, got %0b",
                               want.frame_advanced, out_data.frame_advanced);
                        mismatches++;
                    end
                end
            end
            // one long back-pressure window so the block fills and stalls its input
            if (!hold_done && reports_seen >= HOLD_AT)
            begin
                hold_done <= 1'b1;
                stall_left <= HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                stall_left <= pause_len();
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int    e;
        int    p;
        int    n;
        int    phase_counts [PHASES];
        mode_t phase_modes [PHASES];
        logic [HANDLE_W-1:0] h;
        logic [TIME_W-1:0]   dur;

        phase_counts = '{16, 2, 16, 5, 0, 1, 31, 16, 3, 9, 16, 12};
        phase_modes = '{MODE_LOOP, MODE_PINGPONG, MODE_ONCE, MODE_ONCE_ALT,
                        MODE_PINGPONG, MODE_LOOP, MODE_ONCE, MODE_PINGPONG,
                        MODE_LOOP, MODE_PINGPONG, MODE_ONCE, MODE_ONCE_ALT};
        count_reg = '0;
        mode_reg = MODE_LOOP;
        stop_reg = 1'b0;
        anim_elapsed = '0;
        anim_pos = '0;
        anim_backward = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // table fill, entry 0 first so no unwritten entry is ever shown
        for (e = 0; e < TABLE_DEPTH; e++)
        begin
            h = (e == 0) ? '0 : (e == TABLE_DEPTH - 1) ? '1 : $urandom();
            dur = (e == 0) ? '0 : (e == TABLE_DEPTH - 1) ? '1 : $urandom_range(32'h100, 32'h2_0000);
            pending_items.push_back(make_item(CMD_WRITE, $urandom(), IDX_W'(e), h, dur));
        end
        // zero frames: writes out of range, tick and set frame do nothing
        pending_items.push_back(make_item(CMD_WRITE, '1, 8'd255, '1, '1));
        pending_items.push_back(make_item(CMD_WRITE, '0, 8'd16, $urandom(), '0));
        pending_items.push_back(make_item(CMD_TICK, '1, IDX_W'($urandom()), $urandom(),
                                          $urandom()));
        pending_items.push_back(make_item(CMD_SET, $urandom(), 8'd7, $urandom(), $urandom()));
        drain();

        write_reg(CFG_FRAME_COUNT, 8'd16);
        write_reg(CFG_PLAY_MODE, 8'(MODE_LOOP));
        write_reg(CFG_STOPPED, 8'd0);
        // last frame, saturating accumulator, wrap to zero, restart
        pending_items.push_back(make_item(CMD_SET, '0, 8'd255, '0, '0));
        pending_items.push_back(make_item(CMD_TICK, 32'hFFFF_0000, '0, '1, '1));
        pending_items.push_back(make_item(CMD_TICK, 32'hFFFF_0000, '1, '0, '0));
        pending_items.push_back(make_item(CMD_SET, $urandom(), 8'd200, $urandom(), $urandom()));
        pending_items.push_back(make_item(CMD_RESTART, '1, '1, '1, '1));
        drain();

        for (p = 0; p < PHASES; p++)
        begin
            repeat (8) @(posedge clk);
            quiet = (p == 3 || p == 8);
            write_reg(CFG_FRAME_COUNT, 8'(phase_counts[p]));
            write_reg(CFG_PLAY_MODE, 8'(phase_modes[p]));
            write_reg(CFG_STOPPED, (p == 6 || p == 10) ? 8'd1 : 8'd0);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                pending_items.push_back(random_item());
            drain();
        end

        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tfs_pkg.sv
rtl/tfs_ram.sv
rtl/tfs_ctrl.sv
rtl/tfs_dp.sv
rtl/texture_frame_sequencer.sv
rtl/tfs_checker.sv
tb/texture_frame_sequencer_tb.sv
